// ===== rtl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and codes for the button debouncer with long press and repeat.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned FIELD_W     = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIME       = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_TIME     = 8'd3;

  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_TIME   = 16'd3;
  localparam logic [CFG_DATA_W-1:0] RST_IDLE_TIME       = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_PRESS_TIME = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT_TIME     = 16'd20;

  typedef enum logic [1:0] {
    PH_CLEAN = 2'd0,
    PH_PRESS = 2'd1,
    PH_LOOSE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RELEASED = 2'd1,
    ST_PRESSED  = 2'd2,
    ST_HELD     = 2'd3
  } btn_state_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_time;
    logic [CFG_DATA_W-1:0] idle_time;
    logic [CFG_DATA_W-1:0] long_press_time;
    logic [CFG_DATA_W-1:0] repeat_time;
  } cfg_t;

endpackage

// ===== rtl/bdlp_step.sv =====
// ----------------------------------------------------------------------------
// bdlp_step
// Next-state logic for one tick: debounce, commit, long press, repeat, idle.
// ----------------------------------------------------------------------------
module bdlp_step #(
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  bdlp_pkg::cfg_t       cfg,
  input  logic                 press,
  input  bdlp_pkg::phase_t     phase,
  input  bdlp_pkg::btn_state_t state,
  input  logic [TIME_BITS-1:0] tick,
  input  logic [COUNT_BITS-1:0] repeats,
  input  logic [COUNT_BITS-1:0] idles,
  output bdlp_pkg::phase_t     phase_nxt,
  output bdlp_pkg::btn_state_t state_nxt,
  output logic [TIME_BITS-1:0] tick_nxt,
  output logic [COUNT_BITS-1:0] repeats_nxt,
  output logic [COUNT_BITS-1:0] idles_nxt,
  output logic                 event_nxt
);
  import bdlp_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  logic [TIME_BITS-1:0]  tick_inc;
  logic [TIME_BITS-1:0]  tick_sel;
  logic [CFG_DATA_W-1:0] limit;

  assign tick_inc = (tick == {TIME_BITS{1'b1}}) ? tick : tick + TIME_BITS'(1);

  always_comb begin
    phase_nxt   = phase;
    state_nxt   = state;
    repeats_nxt = repeats;
    idles_nxt   = idles;
    event_nxt   = 1'b0;
    tick_sel    = tick_inc;
    limit       = cfg.debounce_time;
    case (phase)
      PH_CLEAN: begin
        if (!state[1]) begin
          limit = cfg.idle_time;
          if (press) begin
            phase_nxt = PH_PRESS;
            tick_sel  = '0;
          end
        end else begin
          limit = (state == ST_PRESSED) ? cfg.long_press_time : cfg.repeat_time;
          if (!press) begin
            phase_nxt = PH_LOOSE;
            tick_sel  = '0;
          end
        end
      end
      default: begin
        if ((phase == PH_PRESS) != press) begin
          phase_nxt = press ? PH_PRESS : PH_LOOSE;
          tick_sel  = '0;
        end
      end
    endcase

    tick_nxt = tick_sel;

    if (phase != PH_CLEAN) begin
      if (CMP_W'(tick_sel) >= CMP_W'(limit)) begin
        phase_nxt = PH_CLEAN;
        tick_nxt  = '0;
        if (!state[1] && press) begin
          state_nxt   = ST_PRESSED;
          event_nxt   = 1'b1;
          repeats_nxt = '0;
        end else if (state[1] && !press) begin
          state_nxt = ST_RELEASED;
          event_nxt = 1'b1;
          idles_nxt = '0;
        end
      end
    end else if (phase_nxt == PH_CLEAN) begin
      if (CMP_W'(tick_sel) >= CMP_W'(limit)) begin
        tick_nxt  = '0;
        event_nxt = 1'b1;
        if (!state[1]) begin
          idles_nxt = idles + COUNT_BITS'(1);
          state_nxt = ST_IDLE;
        end else begin
          repeats_nxt = repeats + COUNT_BITS'(1);
          state_nxt   = ST_HELD;
        end
      end
    end
  end

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounces a sampled button level and reports press, release, long press,
// repeat and idle periods, one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the button level and yields exactly one
// result beat, registered in the cycle after it is accepted. The block takes
// one beat per clock: the tick update is a compare and increment, and the
// output register lets a new beat in whenever it is empty or being drained,
// so input stalls only while a result waits with out_ready low. Write the
// configuration registers through the cfg port only while the block is idle;
// not enforced. cfg_ready is always high and unknown indexes are dropped.
module button_debounce_long_press #(
  parameter int unsigned TIME_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_pressed_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_event_res,
  output bdlp_pkg::btn_state_t                 out_button_state,
  output logic                                 out_settling,
  output logic [bdlp_pkg::FIELD_W-1:0]         out_repeat_count,
  output logic [bdlp_pkg::FIELD_W-1:0]         out_idle_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bdlp_pkg::*;

  localparam int unsigned CNT_EXT_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

  cfg_t                  cfg_r;
  phase_t                phase_r;
  phase_t                phase_nxt;
  btn_state_t            state_r;
  btn_state_t            state_nxt;
  logic [TIME_BITS-1:0]  tick_r;
  logic [TIME_BITS-1:0]  tick_nxt;
  logic [COUNT_BITS-1:0] repeats_r;
  logic [COUNT_BITS-1:0] repeats_nxt;
  logic [COUNT_BITS-1:0] idles_r;
  logic [COUNT_BITS-1:0] idles_nxt;
  logic                  event_nxt;
  logic                  out_valid_r;
  logic                  in_accept;
  logic [CNT_EXT_W-1:0]  repeats_ext;
  logic [CNT_EXT_W-1:0]  idles_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign repeats_ext = CNT_EXT_W'(repeats_nxt);
  assign idles_ext   = CNT_EXT_W'(idles_nxt);

  bdlp_step #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg         (cfg_r),
    .press       (in_pressed_raw),
    .phase       (phase_r),
    .state       (state_r),
    .tick        (tick_r),
    .repeats     (repeats_r),
    .idles       (idles_r),
    .phase_nxt   (phase_nxt),
    .state_nxt   (state_nxt),
    .tick_nxt    (tick_nxt),
    .repeats_nxt (repeats_nxt),
    .idles_nxt   (idles_nxt),
    .event_nxt   (event_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= RST_DEBOUNCE_TIME;
      cfg_r.idle_time       <= RST_IDLE_TIME;
      cfg_r.long_press_time <= RST_LONG_PRESS_TIME;
      cfg_r.repeat_time     <= RST_REPEAT_TIME;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   cfg_r.debounce_time   <= cfg_data;
        REG_IDLE_TIME:       cfg_r.idle_time       <= cfg_data;
        REG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_data;
        REG_REPEAT_TIME:     cfg_r.repeat_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAN;
      state_r     <= ST_RELEASED;
      tick_r      <= '0;
      repeats_r   <= '0;
      idles_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r   <= phase_nxt;
        state_r   <= state_nxt;
        tick_r    <= tick_nxt;
        repeats_r <= repeats_nxt;
        idles_r   <= idles_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_event_res    <= event_nxt;
      out_button_state <= state_nxt;
      out_settling     <= (phase_nxt != PH_CLEAN);
      out_repeat_count <= repeats_ext[FIELD_W-1:0];
      out_idle_count   <= idles_ext[FIELD_W-1:0];
    end
  end

endmodule
